/* sv/pmm_pkg.sv */
// shared constants and types for the one-mismatch pattern matcher
`timescale 1ns / 1ps
package pmm_pkg;

  // pattern storage and widths
  localparam int MAX_PATTERN = 64;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = 32;
  localparam int MM_W        = 2;

  localparam logic [MM_W-1:0]  MM_SAT  = MM_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_PATTERN_LEN = 1'b0;

  // broadcast control seen by every cell of the row
  typedef struct packed {
    logic              load;
    logic              text;
    logic              start;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  len;
  } pmm_cell_ctrl_t;

  // one result transaction
  typedef struct packed {
    logic              window_full;
    logic              match;
    logic [CNT_W-1:0]  match_start;
    logic [MM_W-1:0]   mismatch_count;
    logic [CNT_W-1:0]  match_total;
  } pmm_result_t;

endpackage

/* sv/pmm_if.sv */
// valid/ready channel interfaces for input items and results
`timescale 1ns / 1ps
interface pmm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [pmm_pkg::CHAR_W-1:0] char_code;
  logic [pmm_pkg::IDX_W-1:0]  pattern_index;
  logic                       text_start;

  modport source (output valid, req_type, char_code, pattern_index, text_start,
                  input ready);
  modport sink (input valid, req_type, char_code, pattern_index, text_start,
                output ready);
endinterface

interface pmm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      window_full;
  logic                      match;
  logic [pmm_pkg::CNT_W-1:0] match_start;
  logic [pmm_pkg::MM_W-1:0]  mismatch_count;
  logic [pmm_pkg::CNT_W-1:0] match_total;

  modport source (output valid, window_full, match, match_start, mismatch_count,
                  match_total, input ready);
  modport sink (input valid, window_full, match, match_start, mismatch_count,
                match_total, output ready);
endinterface

/* sv/pmm_cell.sv */
// one cell of the row: a pattern byte and the partial mismatch count of one alignment
`timescale 1ns / 1ps
module pmm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [pmm_pkg::IDX_W-1:0] cell_idx,
  input  pmm_pkg::pmm_cell_ctrl_t   ctrl,
  input  logic [pmm_pkg::MM_W-1:0]  sum_in,
  output logic [pmm_pkg::MM_W-1:0]  sum_out
);
  import pmm_pkg::*;

  logic [CHAR_W-1:0] pat;
  logic [MM_W-1:0]   pm;
  logic [MM_W-1:0]   base;
  logic              diff;
  logic              in_use;

  // pattern byte, loaded by index
  always_ff @(posedge clk) begin
    if (ctrl.load && ctrl.idx == cell_idx) begin
      pat <= ctrl.ch;
    end
  end

  // count carried on with this position compared, saturating at two
  assign diff = (pat != ctrl.ch);
  assign base = ctrl.start ? '0 : pm;
  assign sum_out = (base == MM_SAT) ? MM_SAT : base + MM_W'(diff);

  assign in_use = ({1'b0, cell_idx} < ctrl.len);

  // count shifts in from the left neighbour; cell zero clears, cells beyond the length hold and clear at a text start
  always_ff @(posedge clk) begin
    if (rst) begin
      pm <= '0;
    end else if (ctrl.text) begin
      if (cell_idx == '0) begin
        pm <= '0;
      end else if (in_use) begin
        pm <= sum_in;
      end else if (ctrl.start) begin
        pm <= '0;
      end
    end
  end

endmodule

/* sv/pmm_cell_row.sv */
// row of matcher cells and selection of the count that closes the window
`timescale 1ns / 1ps
module pmm_cell_row (
  input  logic                     clk,
  input  logic                     rst,
  input  pmm_pkg::pmm_cell_ctrl_t  ctrl,
  output logic [pmm_pkg::MM_W-1:0] fin
);
  import pmm_pkg::*;

  logic [MM_W-1:0]  sums [MAX_PATTERN];
  logic [IDX_W-1:0] last;

  // chain of cells, each but the first fed by its left neighbour
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [MM_W-1:0] left;
    if (j == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = sums[j-1];
    end
    pmm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDX_W'(j)),
      .ctrl     (ctrl),
      .sum_in   (left),
      .sum_out  (sums[j])
    );
  end

  // the cell at the last pattern position gives the full-window count
  assign last = IDX_W'(ctrl.len - LEN_W'(1));
  assign fin  = sums[last];

endmodule

/* sv/pmm_out_buf.sv */
// two-entry result buffer so the input side keeps flowing while a result waits
`timescale 1ns / 1ps
module pmm_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pmm_pkg::pmm_result_t push_data,
  output logic                 space,
  pmm_out_if.source            result
);
  import pmm_pkg::*;

  pmm_result_t slot [2];
  logic [1:0]  cnt;
  logic        pop;

  assign pop   = result.valid && result.ready;
  assign space = (cnt != 2'd2);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  // head is slot 0, the skid entry slot 1
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        slot[0] <= push_data;
      end else begin
        slot[0] <= slot[1];
        slot[1] <= push_data;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot[0] <= push_data;
      end else begin
        slot[1] <= push_data;
      end
    end else if (pop) begin
      slot[0] <= slot[1];
    end
  end

  assign result.valid          = (cnt != 2'd0);
  assign result.window_full    = slot[0].window_full;
  assign result.match          = slot[0].match;
  assign result.match_start    = slot[0].match_start;
  assign result.mismatch_count = slot[0].mismatch_count;
  assign result.match_total    = slot[0].match_total;

  // occupancy stays within two entries
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result buffer occupancy out of range");

  // no push into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !push)
    else $error("push into full result buffer");

  // a waiting result leaves only through a pop
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> result.valid)
    else $error("result dropped while stalled");

endmodule

/* sv/pattern_match_one_mismatch.sv */
// top level: one-mismatch pattern matcher with configuration port and counters
// a result is registered in the result buffer when its text transaction is accepted
// throughput: one transaction per cycle, pattern load or text byte, while the result buffer has space
// all cells update together in the cell row; a two-entry result buffer decouples stalls
// reset: pattern length to one, partial counts and counters to zero, buffer empty
// pattern bytes are not cleared by reset and must be loaded before use
`timescale 1ns / 1ps
module pattern_match_one_mismatch (
  input  logic                           clk,
  input  logic                           rst,
  pmm_in_if.sink                         item,
  pmm_out_if.source                      result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pmm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pmm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pmm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pmm_pkg::*;

  logic [LEN_W-1:0] pattern_len;
  logic [LEN_W-1:0] len_eff;
  logic             cfg_wr;
  logic             reg_sel;

  logic             accept;
  logic             text;
  logic             space;
  pmm_cell_ctrl_t   ctrl;
  logic [MM_W-1:0]  fin;

  logic [CNT_W-1:0] chars_seen;
  logic [CNT_W-1:0] chars_seen_next;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] hit_total_base;
  logic [CNT_W-1:0] hit_total_next;
  logic             full;
  logic             hit;
  pmm_result_t      res;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && (reg_sel == REG_PATTERN_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= LEN_W'(1);
    end else if (cfg_wr) begin
      pattern_len <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (reg_sel == REG_PATTERN_LEN) ?
                  {{(APB_DATA_W-LEN_W){1'b0}}, pattern_len} : '0;

  // length clamped to the usable range
  always_comb begin
    if (pattern_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_len > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_len;
    end
  end

  // input handshake and broadcast to the cells
  assign item.ready = space;
  assign accept     = item.valid && item.ready;
  assign text       = accept && (item.req_type == REQ_TEXT);

  assign ctrl.load  = accept && (item.req_type == REQ_LOAD);
  assign ctrl.text  = text;
  assign ctrl.start = item.text_start;
  assign ctrl.ch    = item.char_code;
  assign ctrl.idx   = item.pattern_index;
  assign ctrl.len   = len_eff;

  pmm_cell_row u_row (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .fin  (fin)
  );

  // text position and match counters, both saturating
  always_comb begin
    if (item.text_start) begin
      chars_seen_next = CNT_W'(1);
      hit_total_base  = '0;
    end else begin
      chars_seen_next = (chars_seen == CNT_MAX) ? chars_seen : chars_seen + CNT_W'(1);
      hit_total_base  = hit_total;
    end
    full = (chars_seen_next >= {{(CNT_W-LEN_W){1'b0}}, len_eff});
    hit  = full && (fin != MM_SAT);
    hit_total_next = (hit && hit_total_base != CNT_MAX) ? hit_total_base + CNT_W'(1)
                                                         : hit_total_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_seen <= '0;
      hit_total  <= '0;
    end else if (text) begin
      chars_seen <= chars_seen_next;
      hit_total  <= hit_total_next;
    end
  end

  // result transaction
  assign res.window_full    = full;
  assign res.match          = hit;
  assign res.match_start    = full ? chars_seen_next - {{(CNT_W-LEN_W){1'b0}}, len_eff} : '0;
  assign res.mismatch_count = full ? fin : '0;
  assign res.match_total    = hit_total_next;

  pmm_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (text),
    .push_data (res),
    .space     (space),
    .result    (result)
  );

  // reset leaves a pattern length of one
  a_len_reset: assert property (@(posedge clk) rst |=> pattern_len == LEN_W'(1))
    else $error("pattern length not restored by reset");

  // a match only comes from a full window
  a_match_full: assert property (@(posedge clk) disable iff (rst)
    text && res.match |-> res.window_full)
    else $error("match reported without full window");

  // within one text the match total never falls
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    (text && !item.text_start) |=> hit_total >= $past(hit_total))
    else $error("match total decreased within a text");

  // the clamped length stays in the usable range
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    len_eff != '0 && len_eff <= LEN_W'(MAX_PATTERN))
    else $error("effective pattern length out of range");

endmodule
